>>> src/rhvp_pkg.sv
// Shared types and constants for the record header varint parser.
// No dependencies; used by every other file of the block but rhvp_if.
package rhvp_pkg;

   // Parse phases: which varint of the cell is being read
   typedef enum logic [1:0] {
      PH_PAYLOAD = 2'd0,
      PH_ROWID   = 2'd1,
      PH_HDRLEN  = 2'd2,
      PH_TYPES   = 2'd3
   } phase_type;

   // Column content kinds
   typedef enum logic [2:0] {
      KIND_NULL     = 3'd0,
      KIND_INTEGER  = 3'd1,
      KIND_FLOAT    = 3'd2,
      KIND_BLOB     = 3'd3,
      KIND_TEXT     = 3'd4,
      KIND_RESERVED = 3'd5
   } kind_type;

   // Error codes, highest applicable one wins
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_RESERVED = 2'd1,
      ERR_OVERFLOW = 2'd2,
      ERR_COLUMNS  = 2'd3
   } err_type;

   // Varint layout: up to eight 7-bit bytes, then one full 8-bit byte
   localparam logic [3:0] VARINT_SHORT_BYTES = 4'd8;
   localparam logic [3:0] VARINT_MAX_BYTES   = 4'd9;
   localparam logic [31:0] U32_MAX           = 32'hFFFF_FFFF;
   localparam logic [30:0] VAR_SIZE_BIAS     = 31'd6;

   // One result item
   typedef struct packed {
      logic [5:0]  column_index;
      logic [31:0] serial_type;
      logic [30:0] content_size;
      logic [31:0] content_offset;
      kind_type    value_kind;
      logic [63:0] row_id;
      logic        last_column;
      err_type     error_code;
   } result_type;

   // Content size of the fixed-size serial types 0..9
   function automatic logic [3:0] small_size(input logic [3:0] t);
      logic [3:0] size;
      unique case (t)
         4'd0:    size = 4'd0;
         4'd1:    size = 4'd1;
         4'd2:    size = 4'd2;
         4'd3:    size = 4'd3;
         4'd4:    size = 4'd4;
         4'd5:    size = 4'd6;
         4'd6:    size = 4'd8;
         4'd7:    size = 4'd8;
         default: size = 4'd0;
      endcase
      return size;
   endfunction

endpackage

>>> src/rhvp_if.sv
// Valid/ready channel interfaces for the cell byte input and the column result output.
// No dependencies.
interface rhvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       cell_start;

   modport source (output valid, output data_byte, output cell_start, input ready);
   modport sink   (input valid, input data_byte, input cell_start, output ready);
endinterface

interface rhvp_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         column_index;
   logic [31:0]        serial_type;
   logic [30:0]        content_size;
   logic [31:0]        content_offset;
   logic [2:0]         value_kind;
   logic signed [63:0] row_id;
   logic               last_column;
   logic [1:0]         error_code;

   modport source (output valid, output column_index, output serial_type,
                   output content_size, output content_offset, output value_kind,
                   output row_id, output last_column, output error_code, input ready);
   modport sink   (input valid, input column_index, input serial_type,
                   input content_size, input content_offset, input value_kind,
                   input row_id, input last_column, input error_code, output ready);
endinterface

>>> src/rhvp_decode.sv
// Serial type decoder: content size and kind of one serial type.
// Depends on rhvp_pkg.
module rhvp_decode (
   input  logic [31:0]       serial_type,
   output logic [30:0]       content_size,
   output rhvp_pkg::kind_type value_kind
);

   logic [30:0] half_type;

   // (t-12)/2 for even and (t-13)/2 for odd both reduce to t/2 - 6
   assign half_type = serial_type[31:1];

   always_comb begin
      if (serial_type <= 32'd9) begin
         content_size = 31'(rhvp_pkg::small_size(serial_type[3:0]));
         if (serial_type == 32'd0 || serial_type == 32'd8 || serial_type == 32'd9) begin
            value_kind = rhvp_pkg::KIND_NULL;
         end else if (serial_type == 32'd7) begin
            value_kind = rhvp_pkg::KIND_FLOAT;
         end else begin
            value_kind = rhvp_pkg::KIND_INTEGER;
         end
      end else if (serial_type <= 32'd11) begin
         content_size = '0;
         value_kind   = rhvp_pkg::KIND_RESERVED;
      end else begin
         content_size = half_type - rhvp_pkg::VAR_SIZE_BIAS;
         value_kind   = serial_type[0] ? rhvp_pkg::KIND_TEXT : rhvp_pkg::KIND_BLOB;
      end
   end

endmodule

>>> src/rhvp_parser.sv
// Parse state and per-byte update: varint assembly, header accounting, column results.
// Depends on rhvp_pkg and rhvp_decode.
module rhvp_parser #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [7:0]             data_byte,
   input  logic                   cell_start,
   output logic                   emit,
   output rhvp_pkg::result_type   result
);

   localparam int CW = $clog2(MAX_COLUMNS + 1);
   localparam int IW = (CW > 6) ? CW : 6;

   rhvp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [63:0] acc_ff, acc_in, cur_acc, acc_step;
   logic [3:0]  cnt_ff, cnt_in, cur_cnt, cnt_step;
   logic [31:0] hl_ff, hl_in, cur_hl;
   logic [31:0] hc_ff, hc_in, cur_hc, hc_step;
   logic [CW-1:0] col_ff, col_in, cur_col;
   logic [31:0] off_ff, off_in, cur_off;
   logic [63:0] rowid_ff, rowid_in, cur_rowid;

   logic        skip, byte_last, done, value_ovf, col_full;
   logic [31:0] type_val;
   logic [30:0] dec_size;
   rhvp_pkg::kind_type dec_kind;
   logic [32:0] off_sum;
   logic [IW-1:0] idx_ext;

   // Cell start clears the parse state for this byte
   always_comb begin
      if (cell_start) begin
         cur_phase = rhvp_pkg::PH_PAYLOAD;
         cur_acc   = '0;
         cur_cnt   = '0;
         cur_hl    = '0;
         cur_hc    = '0;
         cur_col   = '0;
         cur_off   = '0;
         cur_rowid = '0;
      end else begin
         cur_phase = phase_ff;
         cur_acc   = acc_ff;
         cur_cnt   = cnt_ff;
         cur_hl    = hl_ff;
         cur_hc    = hc_ff;
         cur_col   = col_ff;
         cur_off   = off_ff;
         cur_rowid = rowid_ff;
      end
   end

   // Header used up: bytes are ignored until the next cell
   assign skip = (cur_phase == rhvp_pkg::PH_TYPES) && (cur_cnt == '0) && (cur_hc >= cur_hl);

   // Header byte count, saturating
   assign hc_step = ((cur_phase == rhvp_pkg::PH_HDRLEN || cur_phase == rhvp_pkg::PH_TYPES)
                     && cur_hc != rhvp_pkg::U32_MAX) ? cur_hc + 32'd1 : cur_hc;

   // Varint assembly: 7 bits per byte, all 8 bits of the ninth
   assign byte_last = (cur_cnt >= rhvp_pkg::VARINT_SHORT_BYTES);
   assign acc_step  = byte_last ? {cur_acc[55:0], data_byte} : {cur_acc[56:0], data_byte[6:0]};
   assign cnt_step  = byte_last ? rhvp_pkg::VARINT_MAX_BYTES : cur_cnt + 4'd1;
   assign done      = byte_last || !data_byte[7];

   // Serial type, saturated when above 32 bits
   assign value_ovf = |acc_step[63:32];
   assign type_val  = value_ovf ? rhvp_pkg::U32_MAX : acc_step[31:0];

   rhvp_decode u_decode (
      .serial_type  (type_val),
      .content_size (dec_size),
      .value_kind   (dec_kind)
   );

   assign off_sum  = {1'b0, cur_off} + 33'(dec_size);
   assign col_full = (cur_col >= CW'(MAX_COLUMNS));
   assign idx_ext  = IW'(cur_col);

   // Result fields for a completed serial type
   always_comb begin
      result.column_index   = idx_ext[5:0];
      result.serial_type    = type_val;
      result.content_size   = dec_size;
      result.content_offset = cur_off;
      result.value_kind     = dec_kind;
      result.row_id         = cur_rowid;
      result.last_column    = (hc_step >= cur_hl);
      if (col_full) begin
         result.error_code = rhvp_pkg::ERR_COLUMNS;
      end else if (value_ovf || off_sum[32]) begin
         result.error_code = rhvp_pkg::ERR_OVERFLOW;
      end else if (dec_kind == rhvp_pkg::KIND_RESERVED) begin
         result.error_code = rhvp_pkg::ERR_RESERVED;
      end else begin
         result.error_code = rhvp_pkg::ERR_NONE;
      end
   end

   // Next state per accepted byte
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      hl_in    = hl_ff;
      hc_in    = hc_ff;
      col_in   = col_ff;
      off_in   = off_ff;
      rowid_in = rowid_ff;
      emit     = 1'b0;
      if (go) begin
         phase_in = cur_phase;
         acc_in   = cur_acc;
         cnt_in   = cur_cnt;
         hl_in    = cur_hl;
         hc_in    = cur_hc;
         col_in   = cur_col;
         off_in   = cur_off;
         rowid_in = cur_rowid;
         if (!skip) begin
            hc_in  = hc_step;
            acc_in = acc_step;
            cnt_in = cnt_step;
            if (done) begin
               acc_in = '0;
               cnt_in = '0;
               unique case (cur_phase)
                  rhvp_pkg::PH_PAYLOAD: begin
                     phase_in = rhvp_pkg::PH_ROWID;
                  end
                  rhvp_pkg::PH_ROWID: begin
                     rowid_in = acc_step;
                     phase_in = rhvp_pkg::PH_HDRLEN;
                  end
                  rhvp_pkg::PH_HDRLEN: begin
                     hl_in    = type_val;
                     phase_in = rhvp_pkg::PH_TYPES;
                  end
                  rhvp_pkg::PH_TYPES: begin
                     emit   = 1'b1;
                     off_in = off_sum[32] ? rhvp_pkg::U32_MAX : off_sum[31:0];
                     col_in = col_full ? cur_col : cur_col + CW'(1);
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rhvp_pkg::PH_PAYLOAD;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         hl_ff    <= '0;
         hc_ff    <= '0;
         col_ff   <= '0;
         off_ff   <= '0;
         rowid_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         hl_ff    <= hl_in;
         hc_ff    <= hc_in;
         col_ff   <= col_in;
         off_ff   <= off_in;
         rowid_ff <= rowid_in;
      end
   end

endmodule

>>> src/record_header_varint_parser.sv
// Record header varint parser: input register, parse stage and result register.
// Depends on rhvp_pkg, rhvp_if (rhvp_req_if, rhvp_rsp_if) and rhvp_parser.
//
// Usage:
//   req_chan carries the bytes of table-leaf cells in file order, one item per
//   byte; cell_start set on an item marks the first byte of a new cell.
//   rsp_chan carries one item per serial type of the record header: column
//   index, serial type, content size, offset and kind, row id, a last-column
//   flag and an error code. Bytes that complete no serial type give no item.
//   An accepted item waits in the input register until the result register can
//   take a new item; it is then parsed in the parse stage and its result is
//   offered on rsp_chan from the result register.
//   Throughput: one byte per cycle while the receiver does not stall; the
//   combinational varint and header update in the parse stage sets that rate.
//   Reset clears all parse state as at the start of a cell and empties both
//   registers. When the receiver stalls, the result register holds its item,
//   the parse stage waits, and the input register takes a byte only while it
//   is empty; req_chan.ready stays low while it is full.
module record_header_varint_parser #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic            clock,
   input  logic            reset,
   rhvp_req_if.sink        req_chan,
   rhvp_rsp_if.source      rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       out_valid_ff, out_valid_in;
   rhvp_pkg::result_type out_data_ff, result;
   logic       out_free, go, emit, req_fire;

   // Handshake between the two register stages
   assign out_free         = !out_valid_ff || rsp_chan.ready;
   assign go               = in_valid_ff && out_free;
   assign req_chan.ready   = !in_valid_ff || go;
   assign req_fire         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (go && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   rhvp_parser #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .data_byte  (in_byte_ff),
      .cell_start (in_start_ff),
      .emit       (emit),
      .result     (result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_chan.data_byte;
         in_start_ff <= req_chan.cell_start;
      end
      if (go && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.column_index   = out_data_ff.column_index;
   assign rsp_chan.serial_type    = out_data_ff.serial_type;
   assign rsp_chan.content_size   = out_data_ff.content_size;
   assign rsp_chan.content_offset = out_data_ff.content_offset;
   assign rsp_chan.value_kind     = out_data_ff.value_kind;
   assign rsp_chan.row_id         = $signed(out_data_ff.row_id);
   assign rsp_chan.last_column    = out_data_ff.last_column;
   assign rsp_chan.error_code     = out_data_ff.error_code;

endmodule

>>> dv/record_header_varint_parser_tb.sv
// Testbench for record_header_varint_parser: random and directed table-leaf cells go in,
// and each column result is checked against a built-in header decoder.
// Depends on rhvp_pkg, rhvp_if (rhvp_req_if, rhvp_rsp_if) and record_header_varint_parser.
module record_header_varint_parser_tb;

   localparam int MAX_COLS       = 64;
   localparam int TARGET_BYTES   = 1000;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 64;

   typedef logic [7:0] byte_queue_type[$];
   typedef logic [63:0] serial_queue_type[$];

   // Header decoder: tracks the parse of the cell and queues the expected columns
   class column_tracker;
      int                  max_cols;
      rhvp_pkg::phase_type phase;
      logic [63:0]         acc;
      logic [3:0]          nbytes;
      logic [31:0]         hdr_len;
      logic [31:0]         hdr_used;
      logic [31:0]         run_off;
      int                  col_cnt;
      logic [63:0]         row;
      logic [3:0]          fixed_size[10] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd8,
                                              4'd0, 4'd0};
      rhvp_pkg::result_type expected_columns[$];
      int                  errors;
      int                  consumed;
      int                  checked;
      int                  err_seen[4];

      function new(int max_columns);
         max_cols = max_columns;
         restart();
      endfunction

      function void restart();
         phase    = rhvp_pkg::PH_PAYLOAD;
         acc      = '0;
         nbytes   = '0;
         hdr_len  = '0;
         hdr_used = '0;
         run_off  = '0;
         col_cnt  = 0;
         row      = '0;
      endfunction

      function int pending();
         return expected_columns.size();
      endfunction

      // One accepted byte: advance the parse, queue a column when a type varint ends
      function void note_byte(logic [7:0] b, logic start);
         logic [63:0]          v;
         logic [31:0]          t;
         logic [31:0]          sz;
         logic [31:0]          off;
         logic [32:0]          sum;
         logic                 ovf;
         bit                   done;
         rhvp_pkg::kind_type   k;
         rhvp_pkg::err_type    e;
         rhvp_pkg::result_type r;
         if (start) restart();
         // header used up: body bytes are skipped until the next cell
         if (phase == rhvp_pkg::PH_TYPES && nbytes == 4'd0 && hdr_used >= hdr_len) return;
         consumed++;
         if (phase >= rhvp_pkg::PH_HDRLEN && hdr_used != rhvp_pkg::U32_MAX) hdr_used++;

         if (nbytes < rhvp_pkg::VARINT_SHORT_BYTES) begin
            acc    = {acc[56:0], b[6:0]};
            nbytes = nbytes + 4'd1;
            done   = !b[7];
         end else begin
            acc    = {acc[55:0], b};
            nbytes = rhvp_pkg::VARINT_MAX_BYTES;
            done   = 1'b1;
         end
         if (!done) return;
         v      = acc;
         acc    = '0;
         nbytes = '0;

         case (phase)
            rhvp_pkg::PH_PAYLOAD: begin
               phase = rhvp_pkg::PH_ROWID;
               return;
            end
            rhvp_pkg::PH_ROWID: begin
               row   = v;
               phase = rhvp_pkg::PH_HDRLEN;
               return;
            end
            rhvp_pkg::PH_HDRLEN: begin
               hdr_len = (|v[63:32]) ? rhvp_pkg::U32_MAX : v[31:0];
               phase   = rhvp_pkg::PH_TYPES;
               return;
            end
            default: ;
         endcase

         // serial type to size and kind
         ovf = |v[63:32];
         t   = ovf ? rhvp_pkg::U32_MAX : v[31:0];
         if (t <= 32'd9) begin
            sz = {28'd0, fixed_size[t[3:0]]};
            if (t == 32'd0 || t == 32'd8 || t == 32'd9) k = rhvp_pkg::KIND_NULL;
            else if (t == 32'd7) k = rhvp_pkg::KIND_FLOAT;
            else k = rhvp_pkg::KIND_INTEGER;
         end else if (t <= 32'd11) begin
            sz = '0;
            k  = rhvp_pkg::KIND_RESERVED;
         end else if (!t[0]) begin
            sz = (t - 32'd12) >> 1;
            k  = rhvp_pkg::KIND_BLOB;
         end else begin
            sz = (t - 32'd13) >> 1;
            k  = rhvp_pkg::KIND_TEXT;
         end

         // running offset saturates on overflow
         off = run_off;
         sum = {1'b0, off} + {1'b0, sz};
         if (sum[32]) begin
            run_off = rhvp_pkg::U32_MAX;
            ovf     = 1'b1;
         end else begin
            run_off = sum[31:0];
         end

         r.column_index = 6'(col_cnt);
         if (col_cnt >= max_cols) begin
            e = rhvp_pkg::ERR_COLUMNS;
         end else begin
            col_cnt++;
            e = ovf ? rhvp_pkg::ERR_OVERFLOW :
                (k == rhvp_pkg::KIND_RESERVED ? rhvp_pkg::ERR_RESERVED : rhvp_pkg::ERR_NONE);
         end
         r.serial_type    = t;
         r.content_size   = sz[30:0];
         r.content_offset = off;
         r.value_kind     = k;
         r.row_id         = row;
         r.last_column    = (hdr_used >= hdr_len);
         r.error_code     = e;
         expected_columns.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_column(rhvp_pkg::result_type got);
         rhvp_pkg::result_type want;
         if (expected_columns.size() == 0) begin
            $error("unexpected column item: column_index %0d serial_type 0x%0h",
                   got.column_index, got.serial_type);
            errors++;
            return;
         end
         want = expected_columns.pop_front();
         checked++;
         if (!$isunknown(got.error_code)) err_seen[got.error_code]++;
         check_field("column_index", 64'(want.column_index), 64'(got.column_index));
         check_field("serial_type", 64'(want.serial_type), 64'(got.serial_type));
         check_field("content_size", 64'(want.content_size), 64'(got.content_size));
         check_field("content_offset", 64'(want.content_offset), 64'(got.content_offset));
         check_field("value_kind", 64'(want.value_kind), 64'(got.value_kind));
         check_field("row_id", want.row_id, got.row_id);
         check_field("last_column", 64'(want.last_column), 64'(got.last_column));
         check_field("error_code", 64'(want.error_code), 64'(got.error_code));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rhvp_req_if req_chan ();
   rhvp_rsp_if rsp_chan ();

   record_header_varint_parser #(
      .MAX_COLUMNS (MAX_COLS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   column_tracker tracker = new(MAX_COLS);

   int burst_left = 0;
   bit gaps_on    = 1'b1;
   int cells_sent = 0;
   int bytes_sent = 0;

   always #4 clock = ~clock;

   // Monitor: note accepted bytes, check accepted columns
   always @(posedge clock) begin : monitor
      rhvp_pkg::result_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            tracker.note_byte(req_chan.data_byte, req_chan.cell_start);
            bytes_sent++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.column_index   = rsp_chan.column_index;
            got.serial_type    = rsp_chan.serial_type;
            got.content_size   = rsp_chan.content_size;
            got.content_offset = rsp_chan.content_offset;
            got.value_kind     = rhvp_pkg::kind_type'(rsp_chan.value_kind);
            got.row_id         = rsp_chan.row_id;
            got.last_column    = rsp_chan.last_column;
            got.error_code     = rhvp_pkg::err_type'(rsp_chan.error_code);
            tracker.check_column(got);
         end
      end
   end

   // Receiver: ready follows a randomly picked stall mode: always ready, random, rare long stalls or a fixed pattern
   initial begin : receiver
      int  cyc;
      int  stall_left;
      int  mode;
      bit  rdy;
      cyc        = 0;
      stall_left = 0;
      mode       = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 256 == 0) mode = $urandom_range(0, 3);
         if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else begin
            case (mode)
               0: rdy = 1'b1;
               1: rdy = $urandom_range(0, 1);
               2: begin
                  rdy = 1'b1;
                  if ($urandom_range(0, 15) == 0) begin
                     stall_left = $urandom_range(5, 30);
                     rdy        = 1'b0;
                  end
               end
               default: rdy = (cyc % 7) < 4;
            endcase
         end
         rsp_chan.ready <= rdy;
      end
   end

   // Varint encoding; pad adds leading empty groups (still a legal varint)
   function automatic void put_varint(ref byte_queue_type q, input logic [63:0] v,
                                      input int pad);
      int n;
      if (v[63:56] != 8'd0) begin
         for (int i = 0; i < 8; i++) q.push_back({1'b1, v[63 - 7 * i -: 7]});
         q.push_back(v[7:0]);
      end else begin
         n = 1;
         while (n < 8 && (v >> (7 * n)) != 64'd0) n++;
         n = (n + pad > 8) ? 8 : n + pad;
         for (int i = n - 1; i >= 0; i--) q.push_back({i != 0, v[7 * i +: 7]});
      end
   endfunction

   function automatic int pick_pad();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   function automatic logic [63:0] rand_type();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 64'($urandom_range(0, 13));
         4: return 64'($urandom_range(14, 300));
         5: return 64'($urandom_range(0, 70000));
         6: return {32'd0, $urandom};
         7: return {32'd0, 28'hFFF_FFFF, 4'($urandom_range(0, 15))};
         8: return {24'd0, 8'($urandom_range(1, 255)), $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] rand_row();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 200));
         1: return {32'd0, $urandom};
         2: return {$urandom, $urandom};
         default: return $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
      endcase
   endfunction

   // Cell: payload length, row id, header length, serial types, a few body bytes.
   // hdr_adj skews the header length; hdr_huge gives one above 32 bits.
   function automatic void build_cell(ref byte_queue_type q, input logic [63:0] row,
                                      input serial_queue_type types, input int hdr_adj,
                                      input bit hdr_huge);
      byte_queue_type th;
      byte_queue_type hq;
      int             pad;
      int             hl;
      th = {};
      foreach (types[i]) put_varint(th, types[i], pick_pad());
      q = {};
      put_varint(q, 64'($urandom_range(0, 5000)), pick_pad());
      put_varint(q, row, pick_pad());
      hq = {};
      if (hdr_huge) begin
         put_varint(hq, {24'd0, 8'($urandom_range(1, 255)), $urandom}, 0);
      end else begin
         // header length counts its own varint, so solve for the encoded size
         pad = pick_pad();
         for (int len = 1; len <= 9; len++) begin
            hl = th.size() + len + hdr_adj;
            if (hl < 0) hl = 0;
            hq = {};
            put_varint(hq, 64'(hl), pad);
            if (hq.size() == len) break;
         end
      end
      q = {q, hq, th};
      repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
   endfunction

   // Send one byte, with a random gap at the start of each burst
   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.cell_start <= start;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Send the first keep bytes of a cell
   task automatic send_cell(input byte_queue_type q, input bit with_start, input int keep);
      gaps_on = ($urandom_range(0, 3) != 0);
      cells_sent++;
      for (int i = 0; i < keep && i < q.size(); i++) send_byte(q[i], with_start && i == 0);
   endtask

   // Stimulus
   initial begin : stimulus
      byte_queue_type   cell_q;
      serial_queue_type types;
      int               pick;
      int               ncols;
      int               drain;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= 8'd0;
      req_chan.cell_start <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // bytes before any cell start, fixed-size and reserved types
      build_cell(cell_q, 64'd3, '{64'd0, 64'd7, 64'd10, 64'd11, 64'd12, 64'd13}, 0, 1'b0);
      send_cell(cell_q, 1'b0, cell_q.size());
      // 9-byte row id of all ones, remaining integer and constant types
      build_cell(cell_q, 64'hFFFF_FFFF_FFFF_FFFF,
                 '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd8, 64'd9}, 0, 1'b0);
      send_cell(cell_q, 1'b1, cell_q.size());
      // largest type, type overflow, 9-byte type, offset overflow
      build_cell(cell_q, 64'd0, '{64'hFFFF_FFFF, 64'h1_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                                  64'hFFFF_FFF0}, 0, 1'b0);
      send_cell(cell_q, 1'b1, cell_q.size());
      // header with no room for columns (length 1, then 0)
      build_cell(cell_q, 64'd7, '{64'd1}, -1, 1'b0);
      send_cell(cell_q, 1'b1, cell_q.size());
      build_cell(cell_q, 64'd7, '{64'd1}, -2, 1'b0);
      send_cell(cell_q, 1'b1, cell_q.size());
      // type varint that runs past the end of the header
      build_cell(cell_q, 64'd9, '{64'd300, 64'd5}, -2, 1'b0);
      send_cell(cell_q, 1'b1, cell_q.size());
      // header length above 32 bits, cut off by the next cell
      build_cell(cell_q, 64'd11, '{64'd1, 64'd2, 64'd14}, 0, 1'b1);
      send_cell(cell_q, 1'b1, cell_q.size());
      // more columns than the limit
      types = {};
      repeat (MAX_COLS + 3) types.push_back($urandom_range(0, 1) ? 64'd1 : 64'd0);
      build_cell(cell_q, 64'd5, types, 0, 1'b0);
      send_cell(cell_q, 1'b1, cell_q.size());

      // Random cells: mostly well formed, some broken or cut short, some noise
      while (bytes_sent < TARGET_BYTES) begin
         pick  = $urandom_range(0, 99);
         ncols = ($urandom_range(0, 9) == 0) ? $urandom_range(62, 72) : $urandom_range(0, 8);
         types = {};
         repeat (ncols) types.push_back(rand_type());
         if (pick < 70) begin
            build_cell(cell_q, rand_row(), types, 0, 1'b0);
            send_cell(cell_q, 1'b1, cell_q.size());
         end else if (pick < 80) begin
            build_cell(cell_q, rand_row(), types, $urandom_range(0, 6) - 3,
                       $urandom_range(0, 4) == 0);
            send_cell(cell_q, 1'b1, cell_q.size());
         end else if (pick < 90) begin
            build_cell(cell_q, rand_row(), types, 0, 1'b0);
            send_cell(cell_q, 1'b1, $urandom_range(1, cell_q.size()));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
         end
      end
      req_chan.valid <= 1'b0;

      // Drain, then let the pipeline settle
      drain = 0;
      while (tracker.pending() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d expected column items never arrived", tracker.pending());
         tracker.errors++;
      end

      $display("Sent %0d cell bytes in %0d cells (%0d parsed), checked %0d column items.",
               bytes_sent, cells_sent, tracker.consumed, tracker.checked);
      $display("Error codes seen: none %0d, reserved %0d, overflow %0d, too many columns %0d.",
               tracker.err_seen[rhvp_pkg::ERR_NONE], tracker.err_seen[rhvp_pkg::ERR_RESERVED],
               tracker.err_seen[rhvp_pkg::ERR_OVERFLOW], tracker.err_seen[rhvp_pkg::ERR_COLUMNS]);
      if (tracker.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> record_header_varint_parser.f
src/rhvp_pkg.sv
src/rhvp_if.sv
src/rhvp_decode.sv
src/rhvp_parser.sv
src/record_header_varint_parser.sv
dv/record_header_varint_parser_tb.sv
